// File: src/rtg_pkg.sv
// ----------------------------------------------------------------------------
// rtg_pkg
// Shared types, widths, register indexes and constant tables of the tone
// mapping and gamma pipeline.
// ----------------------------------------------------------------------------
package rtg_pkg;

	// Pixel format: unsigned fixed point with FRAC_BITS fraction bits.
	localparam int FRAC_BITS = 16;
	localparam int CW        = 24;
	localparam logic [CW-1:0] CH_MAX = {CW{1'b1}};

	// Luma weights, Q0.16.
	localparam int WGT_W = 16;
	localparam logic [WGT_W-1:0] W_RED   = 16'd21627;
	localparam logic [WGT_W-1:0] W_GREEN = 16'd38666;
	localparam logic [WGT_W-1:0] W_BLUE  = 16'd7209;

	// Tone map datapath widths.
	localparam int PRD_W  = CW + WGT_W;
	localparam int SUM_W  = PRD_W + 1;
	localparam int LUMA_W = SUM_W - WGT_W;
	localparam int OPL_W  = LUMA_W + 1;
	localparam int WW_W   = 2 * CW;
	localparam int NUM_W  = WW_W + 2;
	localparam int WL_W   = CW + OPL_W;
	localparam int HALF_W = 25;
	localparam int DEN_W  = CW + WL_W;
	localparam int CN_W   = CW + NUM_W;
	localparam int DNUM_W = CN_W + FRAC_BITS;

	// Gamma datapath widths.
	localparam int LOG_FRAC  = 20;
	localparam int EXP_STEPS = 20;
	localparam int M_W       = 31;
	localparam int P_W       = 5;
	localparam int LGI_W     = 6;
	localparam int LG_W      = LGI_W + LOG_FRAC;
	localparam int GAM_W     = 16;
	localparam int PR_W      = LG_W + GAM_W + 1;
	localparam int EF_W      = 32;
	localparam int N_W       = PR_W - EF_W;
	localparam int S_W       = N_W + 1;

	// Pipeline depths.
	localparam int TM_PRE   = 6;
	localparam int TM_LAT   = TM_PRE + CW + 1;
	localparam int GM_LAT   = 2 + LOG_FRAC + 1 + EXP_STEPS + 1;
	localparam int TOTAL_LAT = TM_LAT + GM_LAT;

	// Configuration port.
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 24;
	localparam logic [CFG_IDX_W-1:0] REG_TONEMAP = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WHITE   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GAMMA   = 2'd2;

	localparam logic [CW-1:0]    WHITE_RST = 24'd262144;
	localparam logic [GAM_W-1:0] GAMMA_RST = 16'd1862;

	typedef logic [CW-1:0] chan_t;

	typedef struct packed {
		logic [CW-1:0] in_red;
		logic [CW-1:0] in_green;
		logic [CW-1:0] in_blue;
	} pixel_in_t;

	typedef struct packed {
		logic [CW-1:0] out_red;
		logic [CW-1:0] out_green;
		logic [CW-1:0] out_blue;
	} pixel_out_t;

	typedef struct packed {
		logic             tonemap_enable;
		logic [CW-1:0]    white_point;
		logic [GAM_W-1:0] gamma_exponent;
	} cfg_t;

	// Integer square root, evaluated at elaboration only.
	function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
		logic [63:0] v;
		logic [63:0] r;
		logic [63:0] b;
		v = v_in;
		r = '0;
		b = 64'h4000_0000_0000_0000;
		for (int i = 0; i < 32; i++) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// Factor 2^(2^-k) in Q1.30 for exp2 step k (k from 1).
	function automatic logic [M_W-1:0] exp_factor(input int k);
		logic [63:0] c;
		c = isqrt64(64'd1 << 61);
		for (int j = 1; j < k; j++) begin
			c = isqrt64(c << 30);
		end
		return c[M_W-1:0];
	endfunction

endpackage

// File: src/rtg_div.sv
// ----------------------------------------------------------------------------
// rtg_div
// Pipelined restoring divider, one quotient bit per stage, saturating.
// ----------------------------------------------------------------------------
module rtg_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       i_valid,
	input  logic [rtg_pkg::DNUM_W-1:0] i_num,
	input  logic [rtg_pkg::DEN_W-1:0]  i_den,
	input  logic                       i_alt_use,
	input  logic [rtg_pkg::CW-1:0]     i_alt,
	output logic                       o_valid,
	output logic [rtg_pkg::CW-1:0]     o_quot
);
	import rtg_pkg::*;

	logic             v_s       [0:CW];
	logic [DEN_W-1:0] rem_s     [0:CW];
	logic [CW-1:0]    nq_s      [0:CW];
	logic [DEN_W-1:0] den_s     [0:CW];
	logic             sat_s     [0:CW];
	logic             alt_use_s [0:CW];
	logic [CW-1:0]    alt_s     [0:CW];

	logic [DEN_W-1:0] nh_ext;

	// The quotient overflows 24 bits exactly when the upper numerator part
	// is not below the divisor; otherwise it seeds the remainder.
	assign nh_ext = DEN_W'(i_num[DNUM_W-1:CW]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else begin
			v_s[0] <= i_valid;
		end
	end

	always_ff @(posedge clk) begin
		rem_s[0]     <= nh_ext;
		nq_s[0]      <= i_num[CW-1:0];
		den_s[0]     <= i_den;
		sat_s[0]     <= (nh_ext >= i_den);
		alt_use_s[0] <= i_alt_use;
		alt_s[0]     <= i_alt;
	end

	for (genvar j = 1; j <= CW; j++) begin : g_step
		logic [DEN_W:0] trial;
		logic           ge;

		assign trial = {rem_s[j-1], nq_s[j-1][CW-1]};
		assign ge    = (trial >= {1'b0, den_s[j-1]});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[j] <= 1'b0;
			end else begin
				v_s[j] <= v_s[j-1];
			end
		end

		always_ff @(posedge clk) begin
			if (ge) begin
				rem_s[j] <= trial[DEN_W-1:0] - den_s[j-1];
			end else begin
				rem_s[j] <= trial[DEN_W-1:0];
			end
			nq_s[j]      <= {nq_s[j-1][CW-2:0], ge};
			den_s[j]     <= den_s[j-1];
			sat_s[j]     <= sat_s[j-1];
			alt_use_s[j] <= alt_use_s[j-1];
			alt_s[j]     <= alt_s[j-1];
		end
	end

	assign o_valid = v_s[CW];
	assign o_quot  = alt_use_s[CW] ? alt_s[CW] : (sat_s[CW] ? CH_MAX : nq_s[CW]);

endmodule

// File: src/rtg_tonemap.sv
// ----------------------------------------------------------------------------
// rtg_tonemap
// Luma, extended Reinhard scale factor and per-channel division.
// ----------------------------------------------------------------------------
module rtg_tonemap (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               i_valid,
	input  rtg_pkg::pixel_in_t i_pix,
	input  rtg_pkg::cfg_t      cfg,
	output logic               o_valid,
	output rtg_pkg::chan_t     o_ch [3]
);
	import rtg_pkg::*;

	chan_t ch_in [3];
	assign ch_in[0] = i_pix.in_red;
	assign ch_in[1] = i_pix.in_green;
	assign ch_in[2] = i_pix.in_blue;

	logic [CW-1:0] w_c;
	assign w_c = (cfg.white_point == '0) ? CW'(1) : cfg.white_point;

	// Stage 1: weighted channels and squared white point.
	logic             v_s1, en_s1;
	chan_t            ch_s1 [3];
	logic [PRD_W-1:0] prd_s1 [3];
	logic [CW-1:0]    w_s1;
	logic [WW_W-1:0]  ww_s1;

	// Stage 2: luma.
	logic              v_s2, en_s2;
	chan_t             ch_s2 [3];
	logic [LUMA_W-1:0] luma_s2;
	logic [CW-1:0]     w_s2;
	logic [WW_W-1:0]   ww_s2;
	logic [SUM_W-1:0]  sum_c;

	// Stage 3: numerator factor and 1 + luma.
	logic             v_s3, en_s3, lz_s3;
	chan_t            ch_s3 [3];
	logic [NUM_W-1:0] num_s3;
	logic [OPL_W-1:0] opl_s3;
	logic [CW-1:0]    w_s3;

	// Stage 4: partial products.
	logic                       v_s4, en_s4, lz_s4;
	chan_t                      ch_s4 [3];
	logic [CW+HALF_W-1:0]       plo_s4 [3];
	logic [CW+NUM_W-HALF_W-1:0] phi_s4 [3];
	logic [WL_W-1:0]            wl_s4;
	logic [CW-1:0]              w_s4;

	// Stage 5: dividends and divisor halves.
	logic                      v_s5, en_s5, lz_s5;
	chan_t                     ch_s5 [3];
	logic [CN_W-1:0]           cn_s5 [3];
	logic [CW+HALF_W-1:0]      dlo_s5;
	logic [CW+WL_W-HALF_W-1:0] dhi_s5;

	// Stage 6: divisor.
	logic             v_s6, en_s6, lz_s6;
	chan_t            ch_s6 [3];
	logic [CN_W-1:0]  cn_s6 [3];
	logic [DEN_W-1:0] den_s6;

	// Valid flags of the three dividers, always equal.
	logic [2:0] dv;

	assign sum_c = SUM_W'(prd_s1[0]) + SUM_W'(prd_s1[1]) + SUM_W'(prd_s1[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			v_s1 <= i_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		en_s1     <= cfg.tonemap_enable;
		prd_s1[0] <= ch_in[0] * W_RED;
		prd_s1[1] <= ch_in[1] * W_GREEN;
		prd_s1[2] <= ch_in[2] * W_BLUE;
		w_s1      <= w_c;
		ww_s1     <= w_c * w_c;

		en_s2   <= en_s1;
		luma_s2 <= sum_c[WGT_W +: LUMA_W];
		w_s2    <= w_s1;
		ww_s2   <= ww_s1;

		en_s3  <= en_s2;
		lz_s3  <= (luma_s2 == '0);
		num_s3 <= NUM_W'(ww_s2) + (NUM_W'(luma_s2) << FRAC_BITS);
		opl_s3 <= OPL_W'(luma_s2) + (OPL_W'(1) << FRAC_BITS);
		w_s3   <= w_s2;

		en_s4 <= en_s3;
		lz_s4 <= lz_s3;
		wl_s4 <= w_s3 * opl_s3;
		w_s4  <= w_s3;

		en_s5  <= en_s4;
		lz_s5  <= lz_s4;
		dlo_s5 <= w_s4 * wl_s4[HALF_W-1:0];
		dhi_s5 <= w_s4 * wl_s4[WL_W-1:HALF_W];

		en_s6  <= en_s5;
		lz_s6  <= lz_s5;
		den_s6 <= (DEN_W'(dhi_s5) << HALF_W) + DEN_W'(dlo_s5);
	end

	for (genvar c = 0; c < 3; c++) begin : g_ch
		always_ff @(posedge clk) begin
			ch_s1[c]  <= ch_in[c];
			ch_s2[c]  <= ch_s1[c];
			ch_s3[c]  <= ch_s2[c];
			ch_s4[c]  <= ch_s3[c];
			plo_s4[c] <= ch_s3[c] * num_s3[HALF_W-1:0];
			phi_s4[c] <= ch_s3[c] * num_s3[NUM_W-1:HALF_W];
			ch_s5[c]  <= ch_s4[c];
			cn_s5[c]  <= (CN_W'(phi_s4[c]) << HALF_W) + CN_W'(plo_s4[c]);
			ch_s6[c]  <= ch_s5[c];
			cn_s6[c]  <= cn_s5[c];
		end

		// Bypass passes the channel through; zero luma forces zero.
		rtg_div u_div (
			.clk       (clk),
			.arst_n    (arst_n),
			.i_valid   (v_s6),
			.i_num     ({cn_s6[c], {FRAC_BITS{1'b0}}}),
			.i_den     (den_s6),
			.i_alt_use (!en_s6 || lz_s6),
			.i_alt     (en_s6 ? '0 : ch_s6[c]),
			.o_valid   (dv[c]),
			.o_quot    (o_ch[c])
		);
	end

	assign o_valid = &dv;

endmodule

// File: src/rtg_gamma.sv
// ----------------------------------------------------------------------------
// rtg_gamma
// Per-channel power function through a pipelined log2, multiply and exp2.
// ----------------------------------------------------------------------------
module rtg_gamma (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      i_valid,
	input  logic [rtg_pkg::CW-1:0]    i_x,
	input  logic [rtg_pkg::GAM_W-1:0] i_gamma,
	output logic                      o_valid,
	output logic [rtg_pkg::CW-1:0]    o_y
);
	import rtg_pkg::*;

	// Normalize: leading one position, then mantissa in Q1.30.
	logic           v_g1, xz_g1;
	logic [CW-1:0]  x_g1;
	logic [P_W-1:0] p_g1;
	logic [P_W-1:0] p_c;

	always_comb begin
		p_c = '0;
		for (int i = 0; i < CW; i++) begin
			if (i_x[i]) begin
				p_c = P_W'(i);
			end
		end
	end

	// Log stages, index 0 is the normalized input.
	logic                v_l  [0:LOG_FRAC];
	logic                xz_l [0:LOG_FRAC];
	logic [P_W-1:0]      p_l  [0:LOG_FRAC];
	logic [M_W-1:0]      m_l  [0:LOG_FRAC];
	logic [LOG_FRAC-1:0] fr_l [0:LOG_FRAC];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_g1   <= 1'b0;
			v_l[0] <= 1'b0;
		end else begin
			v_g1   <= i_valid;
			v_l[0] <= v_g1;
		end
	end

	always_ff @(posedge clk) begin
		x_g1    <= i_x;
		p_g1    <= p_c;
		xz_g1   <= (i_x == '0);
		m_l[0]  <= M_W'(x_g1) << (P_W'(M_W - 1) - p_g1);
		p_l[0]  <= p_g1;
		xz_l[0] <= xz_g1;
		fr_l[0] <= '0;
	end

	for (genvar j = 1; j <= LOG_FRAC; j++) begin : g_log
		logic [2*M_W-1:0] sq;
		logic [M_W:0]     t;

		assign sq = m_l[j-1] * m_l[j-1];
		assign t  = sq[2*M_W-1:M_W-1];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_l[j] <= 1'b0;
			end else begin
				v_l[j] <= v_l[j-1];
			end
		end

		always_ff @(posedge clk) begin
			m_l[j]  <= t[M_W] ? t[M_W:1] : t[M_W-1:0];
			fr_l[j] <= {fr_l[j-1][LOG_FRAC-2:0], t[M_W]};
			p_l[j]  <= p_l[j-1];
			xz_l[j] <= xz_l[j-1];
		end
	end

	// Log times exponent.
	logic [LGI_W-1:0]       pe_c;
	logic signed [LG_W-1:0] lg_c;
	logic signed [GAM_W:0]  gs_c;
	logic signed [PR_W-1:0] prod_c;

	assign pe_c   = LGI_W'(p_l[LOG_FRAC]) - LGI_W'(FRAC_BITS);
	assign lg_c   = $signed({pe_c, fr_l[LOG_FRAC]});
	assign gs_c   = $signed({1'b0, i_gamma});
	assign prod_c = lg_c * gs_c;

	// Exp stages, index 0 is the product split into integer and fraction.
	logic                 v_e  [0:EXP_STEPS];
	logic                 xz_e [0:EXP_STEPS];
	logic [N_W-1:0]       n_e  [0:EXP_STEPS];
	logic [EXP_STEPS-1:0] f_e  [0:EXP_STEPS];
	logic [M_W-1:0]       r_e  [0:EXP_STEPS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_e[0] <= 1'b0;
		end else begin
			v_e[0] <= v_l[LOG_FRAC];
		end
	end

	always_ff @(posedge clk) begin
		xz_e[0] <= xz_l[LOG_FRAC];
		n_e[0]  <= prod_c[PR_W-1:EF_W];
		f_e[0]  <= prod_c[EF_W-1 -: EXP_STEPS];
	end

	assign r_e[0] = M_W'(1) << (M_W - 1);

	for (genvar k = 1; k <= EXP_STEPS; k++) begin : g_exp
		localparam logic [M_W-1:0] FACTOR = exp_factor(k);
		logic [2*M_W-1:0] pr;

		assign pr = r_e[k-1] * FACTOR;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_e[k] <= 1'b0;
			end else begin
				v_e[k] <= v_e[k-1];
			end
		end

		always_ff @(posedge clk) begin
			r_e[k]  <= f_e[k-1][EXP_STEPS-1] ? pr[2*M_W-2:M_W-1] : r_e[k-1];
			f_e[k]  <= f_e[k-1] << 1;
			n_e[k]  <= n_e[k-1];
			xz_e[k] <= xz_e[k-1];
		end
	end

	// Final scaling by 2^(n + FRAC_BITS - 30) with saturation.
	logic signed [S_W-1:0] s_c;
	logic signed [S_W-1:0] ns_c;
	logic [M_W+CW-1:0]     up_c;
	logic [CW-1:0]         y_c;

	assign s_c  = $signed({n_e[EXP_STEPS][N_W-1], n_e[EXP_STEPS]})
		+ S_W'(FRAC_BITS - (M_W - 1));
	assign ns_c = -s_c;
	assign up_c = (M_W+CW)'(r_e[EXP_STEPS]) << s_c[P_W-1:0];

	always_comb begin
		if (xz_e[EXP_STEPS]) begin
			y_c = '0;
		end else if (s_c >= 0) begin
			if (s_c > S_W'(CW)) begin
				y_c = CH_MAX;
			end else if (up_c > (M_W+CW)'(CH_MAX)) begin
				y_c = CH_MAX;
			end else begin
				y_c = up_c[CW-1:0];
			end
		end else if (ns_c >= S_W'(M_W)) begin
			y_c = '0;
		end else begin
			y_c = CW'(r_e[EXP_STEPS] >> ns_c[P_W-1:0]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			o_valid <= 1'b0;
		end else begin
			o_valid <= v_e[EXP_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		o_y <= y_c;
	end

	// A zero channel leaves the unit as zero whatever the exponent.
	a_zero_in_zero_out: assert property (@(posedge clk) disable iff (!arst_n)
		(i_valid && i_x == '0) |-> ##GM_LAT (o_valid && o_y == '0))
		else $error("zero channel did not give zero");

endmodule

// File: src/reinhard_tonemap_gamma.sv
// ----------------------------------------------------------------------------
// reinhard_tonemap_gamma
// HDR pixel tone mapping (extended Reinhard) followed by gamma, Q8.16.
// ----------------------------------------------------------------------------
// Usage: one RGB pixel item is taken at each clock edge where start is high
// and busy is low. busy is always low, so an item may enter in every cycle.
// Each result item appears on result for exactly one cycle with done high;
// the receiver must take it then, as it cannot stall the pipeline.
// Throughput is one item per cycle. The depth is set by the tone map front
// end (6 stages), the restoring divider (1 + 24 stages, one quotient bit per
// stage) and the gamma unit (normalize, 20 log2 squaring stages, one
// multiply, 20 exp2 stages and an output shift).
// Registers are written through cfg_valid/cfg_ready/cfg_index/cfg_data;
// cfg_ready is always high. Write them only while no item is in flight.
// Reset clears every valid bit, so no done strobe follows reset, and loads
// tonemap_enable = 1, white_point = 4.0 and gamma_exponent = 1862.
// ----------------------------------------------------------------------------
module reinhard_tonemap_gamma (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  rtg_pkg::pixel_in_t             pixel,
	output logic                           done,
	output rtg_pkg::pixel_out_t            result,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [rtg_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rtg_pkg::CFG_DATA_W-1:0] cfg_data
);
	import rtg_pkg::*;

	// The pipeline never holds off new items or register writes.
	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	logic             tonemap_enable_q;
	logic [CW-1:0]    white_point_q;
	logic [GAM_W-1:0] gamma_exponent_q;
	cfg_t             cfg;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tonemap_enable_q <= 1'b1;
			white_point_q    <= WHITE_RST;
			gamma_exponent_q <= GAMMA_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_TONEMAP: tonemap_enable_q <= cfg_data[0];
				REG_WHITE:   white_point_q    <= cfg_data[CW-1:0];
				REG_GAMMA:   gamma_exponent_q <= cfg_data[GAM_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg.tonemap_enable = tonemap_enable_q;
	assign cfg.white_point    = white_point_q;
	assign cfg.gamma_exponent = gamma_exponent_q;

	// Tone map: luma, Reinhard scale and per-channel division.
	logic  tm_valid;
	chan_t tm_ch [3];

	rtg_tonemap u_tonemap (
		.clk     (clk),
		.arst_n  (arst_n),
		.i_valid (start && !busy),
		.i_pix   (pixel),
		.cfg     (cfg),
		.o_valid (tm_valid),
		.o_ch    (tm_ch)
	);

	// Gamma: one unit per channel, running in lockstep, so their valid
	// flags always agree.
	chan_t      gm_y [3];
	logic [2:0] gv;

	for (genvar c = 0; c < 3; c++) begin : g_gamma
		rtg_gamma u_gamma (
			.clk     (clk),
			.arst_n  (arst_n),
			.i_valid (tm_valid),
			.i_x     (tm_ch[c]),
			.i_gamma (cfg.gamma_exponent),
			.o_valid (gv[c]),
			.o_y     (gm_y[c])
		);
	end

	assign done = &gv;

	assign result.out_red   = gm_y[0];
	assign result.out_green = gm_y[1];
	assign result.out_blue  = gm_y[2];

	// Every accepted item comes out, and done is never raised without one.
	a_done_timing: assert property (@(posedge clk) disable iff (!arst_n)
		done == $past(start && !busy && arst_n, TOTAL_LAT))
		else $error("done strobe out of step with accepted items");

	// A black pixel stays black in both modes.
	a_black_pixel: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && pixel == '0) |-> ##TOTAL_LAT (result == '0))
		else $error("black pixel did not give black result");

	// A zero green channel gives zero green, as the common scale multiplies each channel.
	a_zero_green: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && pixel.in_green == '0) |-> ##TOTAL_LAT
		(result.out_green == '0))
		else $error("zero green channel did not give zero");

endmodule

// File: tb/tb_reinhard_tonemap_gamma.sv
// ----------------------------------------------------------------------------
// tb_reinhard_tonemap_gamma
// Self-checking bench for the tone mapping and gamma pipeline. A directed
// table covers zero, extreme and degenerate pixels under several register
// settings. Random pixels then run under a series of settings that include
// the register extremes. Every result is compared with a written-in expected
// pixel or with a bit-exact software model of the fixed-point datapath.
// ----------------------------------------------------------------------------
module tb_reinhard_tonemap_gamma;
	import rtg_pkg::*;

	logic       clk;
	logic       arst_n;
	logic       start;
	logic       busy;
	pixel_in_t  pixel;
	logic       done;
	pixel_out_t result;
	logic       cfg_valid;
	logic       cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	reinhard_tonemap_gamma DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .pixel(pixel),
		.done(done), .result(result), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// Local copy of the register file, updated on every write we issue.
	logic             tm_on;
	logic [CW-1:0]    white;
	logic [GAM_W-1:0] gam;

	// exp2 factors 2^(2^-k) in Q1.30, built once at time zero.
	logic [63:0] exp_tab [1:EXP_STEPS];

	pixel_out_t pending_pixels[$];
	int errors;
	int checked;
	int cycles;
	int cfg_writes;
	bit allow_gaps;

	// One row of the directed table. When known is set the expected pixel is
	// written in; otherwise the model supplies it.
	typedef struct {
		logic             tm;
		logic [CW-1:0]    wp;
		logic [GAM_W-1:0] gm;
		pixel_in_t        pix;
		bit               known;
		pixel_out_t       exp_pix;
	} row_t;
	row_t rows[$];

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [63:0] sqrt_floor(input logic [63:0] v_in);
		logic [63:0] v;
		logic [63:0] r;
		logic [63:0] b;
		v = v_in;
		r = '0;
		b = 64'd1 << 62;
		while (b > v && b != 0)
			b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// Raise one channel to the programmed exponent: log2 by repeated squaring
	// (20 fraction bits), multiply by the Q4.12 exponent, then exp2 by
	// multiplying the selected root-of-two factors. Truncation throughout.
	function automatic chan_t gamma_channel(input chan_t x);
		int          p;
		int          n;
		int          s;
		logic [63:0] m;
		logic [63:0] f;
		logic [63:0] r;
		logic [63:0] biased;
		longint      frac;
		longint      lg;
		longint      prod;
		if (x == 0)
			return '0;
		p = 23;
		while (x[p] == 1'b0)
			p--;
		m = 64'(x) << (30 - p);
		frac = 0;
		for (int k = 1; k <= LOG_FRAC; k++) begin
			m = (m * m) >> 30;
			if (m >= (64'd1 << 31)) begin
				m = m >> 1;
				frac = frac | (longint'(1) << (LOG_FRAC - k));
			end
		end
		lg = longint'(p - FRAC_BITS) * (longint'(1) << LOG_FRAC) + frac;
		prod = lg * longint'({48'd0, gam});
		biased = prod + (longint'(512) << 32);
		n = int'(biased >> 32) - 512;
		f = biased & 64'hFFFF_FFFF;
		r = 64'd1 << 30;
		for (int k = 1; k <= EXP_STEPS; k++)
			if (f[32-k])
				r = (r * exp_tab[k]) >> 30;
		s = n + FRAC_BITS - 30;
		if (s >= 0) begin
			if (s > 24)
				return CH_MAX;
			r = r << s;
			return (r > 64'(CH_MAX)) ? CH_MAX : r[CW-1:0];
		end
		if (-s >= 63)
			return '0;
		r = r >> (-s);
		return r[CW-1:0];
	endfunction

	// Expected output pixel for the current register settings.
	function automatic pixel_out_t tonemap_pixel(input pixel_in_t pix);
		chan_t        ch [3];
		chan_t        o  [3];
		logic [127:0] luma;
		logic [127:0] w;
		logic [127:0] w2;
		logic [127:0] num;
		logic [127:0] den;
		logic [127:0] q;
		ch[0] = pix.in_red;
		ch[1] = pix.in_green;
		ch[2] = pix.in_blue;
		if (tm_on) begin
			luma = (128'(ch[0]) * W_RED + 128'(ch[1]) * W_GREEN
				+ 128'(ch[2]) * W_BLUE) >> 16;
			if (luma == 0) begin
				ch[0] = '0; ch[1] = '0; ch[2] = '0;
			end else begin
				// A zero white point is out of range; the block treats it as one.
				w = (white == 0) ? 128'd1 : 128'(white);
				w2 = w * w;
				num = w2 + (luma << FRAC_BITS);
				den = w2 * ((128'd1 << FRAC_BITS) + luma);
				for (int i = 0; i < 3; i++) begin
					q = ((128'(ch[i]) << FRAC_BITS) * num) / den;
					ch[i] = (q > 128'(CH_MAX)) ? CH_MAX : q[CW-1:0];
				end
			end
		end
		for (int i = 0; i < 3; i++)
			o[i] = gamma_channel(ch[i]);
		return '{out_red: o[0], out_green: o[1], out_blue: o[2]};
	endfunction

	// Results cannot be held off, so every done cycle is checked against the
	// oldest expectation. Sampling at the edge sees the pre-edge values.
	always @(posedge clk) begin
		pixel_out_t want;
		chan_t      e [3];
		chan_t      a [3];
		if (arst_n && done) begin
			if (pending_pixels.size() == 0) begin
				$display("%0t: unexpected result %h", $time, result);
				errors++;
			end else begin
				want = pending_pixels.pop_front();
				e = '{want.out_red, want.out_green, want.out_blue};
				a = '{result.out_red, result.out_green, result.out_blue};
				for (int i = 0; i < 3; i++)
					if (e[i] !== a[i]) begin
						$display("%0t: channel %0d expected %h actual %h",
							$time, i, e[i], a[i]);
						errors++;
					end
				checked++;
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycles++;
		if (cycles > 300000) begin
			$display("timeout with %0d results outstanding", pending_pixels.size());
			$display("FAIL");
			$finish;
		end
	end

	// Append one row to the directed table.
	task automatic add_row(input row_t r);
		rows = {rows, r};
	endtask

	// Write one register through the configuration channel.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == REG_TONEMAP)
			tm_on = val[0];
		else if (idx == REG_WHITE)
			white = val[CW-1:0];
		else if (idx == REG_GAMMA)
			gam = val[GAM_W-1:0];
		cfg_writes++;
	endtask

	// Registers change only with the pipeline empty: wait for every expected
	// result, then a full pipeline depth for safety.
	task automatic program_regs(input logic tm, input logic [CW-1:0] wp,
			input logic [GAM_W-1:0] gm);
		start <= 1'b0;
		wait (pending_pixels.size() == 0);
		repeat (TOTAL_LAT + 4) @(posedge clk);
		write_reg(REG_TONEMAP, {23'd0, tm});
		write_reg(REG_WHITE, wp);
		write_reg(REG_GAMMA, {8'd0, gm});
	endtask

	// Present one item and hold it until accepted. start stays high after
	// acceptance so the next item can follow back to back; an idle burst
	// lowers it only when one is chosen.
	task automatic send_pixel(input pixel_in_t pix, input bit known, input pixel_out_t want);
		int         gap;
		pixel_out_t exp_pix;
		start <= 1'b1;
		pixel <= pix;
		do @(posedge clk); while (busy);
		exp_pix = known ? want : tonemap_pixel(pix);
		pending_pixels = {pending_pixels, exp_pix};
		if (allow_gaps && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 16);
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Random channel values that mix full range, small values, zeros, single
	// bits and saturation.
	function automatic chan_t rand_chan();
		case ($urandom_range(0, 7))
			0:       return '0;
			1:       return CH_MAX;
			2:       return chan_t'($urandom_range(0, 7));
			3:       return chan_t'(1) << $urandom_range(0, CW - 1);
			4:       return chan_t'($urandom_range(0, 16'hFFFF));
			default: return chan_t'($urandom());
		endcase
	endfunction

	function automatic pixel_in_t rand_pixel();
		return '{in_red: rand_chan(), in_green: rand_chan(), in_blue: rand_chan()};
	endfunction

	localparam pixel_out_t ZERO_OUT = '{default: '0};
	localparam pixel_out_t UNIT_OUT = '{out_red: 24'd65536, out_green: 24'd0,
		out_blue: 24'd65536};

	initial begin
		logic             ctm;
		logic [CW-1:0]    cwp;
		logic [GAM_W-1:0] cgm;
		arst_n = 1'b0;
		start = 1'b0;
		pixel = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_TONEMAP;
		cfg_data = '0;
		errors = 0;
		checked = 0;
		cycles = 0;
		cfg_writes = 0;
		allow_gaps = 1'b1;
		tm_on = 1'b1;
		white = WHITE_RST;
		gam = GAMMA_RST;
		exp_tab[1] = sqrt_floor(64'd1 << 61);
		for (int k = 2; k <= EXP_STEPS; k++)
			exp_tab[k] = sqrt_floor(exp_tab[k-1] << 30);

		// Directed rows. The first group runs on the reset settings.
		add_row('{1, WHITE_RST, GAMMA_RST, '{0, 0, 0}, 1, ZERO_OUT});
		add_row('{1, WHITE_RST, GAMMA_RST, '{CH_MAX, CH_MAX, CH_MAX}, 0, ZERO_OUT});
		// Tiny channels give zero luma, hence all-zero output.
		add_row('{1, WHITE_RST, GAMMA_RST, '{1, 0, 0}, 1, ZERO_OUT});
		add_row('{1, WHITE_RST, GAMMA_RST, '{0, 1, 0}, 1, ZERO_OUT});
		add_row('{1, WHITE_RST, GAMMA_RST, '{0, 0, 1}, 1, ZERO_OUT});
		add_row('{1, WHITE_RST, GAMMA_RST, '{65536, 65536, 65536}, 0, ZERO_OUT});
		// A zero channel stays zero while the others are mapped.
		add_row('{1, WHITE_RST, GAMMA_RST, '{65536, 0, 65536}, 0, ZERO_OUT});
		// Gray at the white point.
		add_row('{1, WHITE_RST, GAMMA_RST, '{WHITE_RST, WHITE_RST, WHITE_RST}, 0,
			ZERO_OUT});
		add_row('{1, WHITE_RST, GAMMA_RST, '{CH_MAX, 0, 0}, 0, ZERO_OUT});
		// Tone map off, zero exponent: nonzero channels give exactly 1.0.
		add_row('{0, WHITE_RST, 0, '{5, 0, CH_MAX}, 1, UNIT_OUT});
		add_row('{0, WHITE_RST, 0, '{0, 0, 0}, 1, ZERO_OUT});
		add_row('{0, WHITE_RST, 0, '{65536, 0, 1}, 1, UNIT_OUT});
		add_row('{0, WHITE_RST, 4096, '{123456, CH_MAX, 1}, 0, ZERO_OUT});
		add_row('{0, WHITE_RST, 16'hFFFF, '{CH_MAX, 65536, 65537}, 0, ZERO_OUT});
		add_row('{0, WHITE_RST, 16'hFFFF, '{1, 2, 65535}, 0, ZERO_OUT});
		// Extreme white points.
		add_row('{1, 1, GAMMA_RST, '{65536, 65536, 65536}, 0, ZERO_OUT});
		add_row('{1, 1, GAMMA_RST, '{CH_MAX, CH_MAX, CH_MAX}, 0, ZERO_OUT});
		add_row('{1, CH_MAX, GAMMA_RST, '{CH_MAX, CH_MAX, CH_MAX}, 0, ZERO_OUT});
		add_row('{1, CH_MAX, GAMMA_RST, '{4, 3, 9}, 0, ZERO_OUT});
		add_row('{1, CH_MAX, 0, '{65536, 0, 300}, 0, ZERO_OUT});
		add_row('{1, CH_MAX, 16'hFFFF, '{200000, 7, CH_MAX}, 0, ZERO_OUT});

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i]) begin
			if (rows[i].tm !== tm_on || rows[i].wp !== white || rows[i].gm !== gam)
				program_regs(rows[i].tm, rows[i].wp, rows[i].gm);
			send_pixel(rows[i].pix, rows[i].known, rows[i].exp_pix);
		end

		// Random phases, each under its own settings. The last phase runs at
		// full rate with no idle bursts.
		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: begin ctm = 1'b1; cwp = WHITE_RST; cgm = GAMMA_RST; end
				1: begin ctm = 1'b0; cwp = CH_MAX; cgm = 16'd4096; end
				2: begin ctm = 1'b1; cwp = 24'd1; cgm = 16'hFFFF; end
				3: begin ctm = 1'b1; cwp = CH_MAX; cgm = 16'd0; end
				4: begin ctm = 1'b0; cwp = 24'd1; cgm = 16'hFFFF; end
				5: begin
					ctm = 1'b1;
					cwp = CW'($urandom_range(1, CH_MAX));
					cgm = GAM_W'($urandom());
				end
				6: begin
					ctm = 1'b0;
					cwp = CW'($urandom_range(1, CH_MAX));
					cgm = GAM_W'($urandom());
				end
				default: begin ctm = 1'b1; cwp = 24'd65536; cgm = GAMMA_RST; end
			endcase
			program_regs(ctm, cwp, cgm);
			allow_gaps = (ph != 7);
			for (int n = 0; n < 180; n++)
				send_pixel(rand_pixel(), 0, ZERO_OUT);
		end
		start <= 1'b0;

		wait (pending_pixels.size() == 0);
		repeat (TOTAL_LAT + 10) @(posedge clk);

		$display("Checked %0d pixel results over %0d register writes,", checked, cfg_writes);
		$display("with tone mapping on and off and white point and exponent extremes.");
		if (errors == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
